// ===== design/sobel_pkg.sv =====
// sobel_pkg: shared constants, types and state encodings for the sobel edge block
// no dependencies; imported by every module of the block
`default_nettype none
package sobel_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int PIX_W          = 24;
	localparam int WIDTH_W        = 11;
	localparam int HEIGHT_W       = 13;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 1;
	localparam int GRAD_W         = 11;
	localparam int ABS_W          = 10;
	localparam int SUM_W          = 21;

	localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(480);
	localparam logic [SUM_W-1:0]    SAT_SUM    = SUM_W'(65280);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0] pcol_t;
	typedef pcol_t [2:0] win_t;
	typedef logic [2:0][7:0] rgb8_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_GO,
		S_BUSY,
		S_WAIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_SQ,
		M_ROOT,
		M_RND
	} mag_state_t;

endpackage
`default_nettype wire

// ===== design/sobel_lbuf.sv =====
// sobel_lbuf: line store holding the two previous rows, one entry per column
// synchronous memory with registered read; uses sobel_pkg
`default_nettype none
module sobel_lbuf #(
	parameter int DEPTH = sobel_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [AW-1:0]                rd_addr,
	output logic      [2*sobel_pkg::PIX_W-1:0] rd_data,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [2*sobel_pkg::PIX_W-1:0] wr_data
);
	import sobel_pkg::*;

	logic [2*PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/sobel_mag.sv =====
// sobel_mag: sobel gradients and rounded saturated magnitude for three channels
// one root bit per cycle; uses sobel_pkg
`default_nettype none
module sobel_mag (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sobel_pkg::win_t   win,
	output logic                   done,
	output sobel_pkg::rgb8_t       mag
);
	import sobel_pkg::*;

	mag_state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic [2:0][ABS_W-1:0] ax_q, ay_q;
	logic [2:0][SUM_W-1:0] s_q;
	logic [2:0][7:0] n_q;

	logic [2:0][ABS_W-1:0] ax_d, ay_d;
	logic [2:0][SUM_W-1:0] s_d;
	logic [2:0][7:0] n_step;
	logic [2:0][7:0] n_rnd;

	always_comb begin
		logic [9:0] lft, rgt, top, bot;
		logic signed [GRAD_W-1:0] gx, gy;
		for (int ch = 0; ch < 3; ch++) begin
			rgt = 10'(win[2][0][8*ch +: 8]) + {1'b0, win[2][1][8*ch +: 8], 1'b0}
				+ 10'(win[2][2][8*ch +: 8]);
			lft = 10'(win[0][0][8*ch +: 8]) + {1'b0, win[0][1][8*ch +: 8], 1'b0}
				+ 10'(win[0][2][8*ch +: 8]);
			top = 10'(win[0][0][8*ch +: 8]) + {1'b0, win[1][0][8*ch +: 8], 1'b0}
				+ 10'(win[2][0][8*ch +: 8]);
			bot = 10'(win[0][2][8*ch +: 8]) + {1'b0, win[1][2][8*ch +: 8], 1'b0}
				+ 10'(win[2][2][8*ch +: 8]);
			gx = signed'({1'b0, rgt}) - signed'({1'b0, lft});
			gy = signed'({1'b0, top}) - signed'({1'b0, bot});
			ax_d[ch] = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
			ay_d[ch] = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
		end
	end

	always_comb begin
		logic [2*ABS_W-1:0] sx, sy;
		logic [7:0] t;
		logic [15:0] tt, nn;
		logic [SUM_W-1:0] rem;
		logic [8:0] n1;
		for (int ch = 0; ch < 3; ch++) begin
			sx = ax_q[ch] * ax_q[ch];
			sy = ay_q[ch] * ay_q[ch];
			s_d[ch] = SUM_W'(sx) + SUM_W'(sy);
			t = n_q[ch] | (8'd1 << cnt_q);
			tt = t * t;
			n_step[ch] = (SUM_W'(tt) <= s_q[ch]) ? t : n_q[ch];
			nn = n_q[ch] * n_q[ch];
			rem = s_q[ch] - SUM_W'(nn);
			n1 = {1'b0, n_q[ch]} + 9'(rem > SUM_W'(n_q[ch]));
			if (s_q[ch] > SAT_SUM || n1[8]) begin
				n_rnd[ch] = 8'hff;
			end else begin
				n_rnd[ch] = n1[7:0];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		done = 1'b0;
		case (state_q)
			M_IDLE: begin
				if (start) begin
					state_d = M_SQ;
				end
			end
			M_SQ: state_d = M_ROOT;
			M_ROOT: begin
				if (cnt_q == 3'd0) begin
					state_d = M_RND;
				end
			end
			M_RND: begin
				done = 1'b1;
				state_d = M_IDLE;
			end
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				ax_q <= ax_d;
				ay_q <= ay_d;
			end
			M_SQ: begin
				s_q <= s_d;
				n_q <= '0;
				cnt_q <= 3'd7;
			end
			M_ROOT: begin
				n_q <= n_step;
				cnt_q <= cnt_q - 3'd1;
			end
			M_RND: mag <= n_rnd;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/sobel_edge_magnitude_rgb_top.sv =====
// sobel_edge_magnitude_rgb_top: streaming 3x3 sobel edge magnitude on rgb pixels
// uses sobel_pkg, sobel_lbuf, sobel_mag
//
// pixels enter in raster order on the in_ beat channel; each pixel releases zero
// to four results on the out_ channel, tagged with row and column, the final one
// of a pixel flagged by last_of_run. neighbours outside the frame are black.
// image_width and image_height must be written on the cfg port while idle; the block does not enforce this.
// an input beat goes through the S_IDLE and S_RD states when it releases nothing,
// plus S_GO, S_BUSY and S_WAIT per released result: the magnitude unit forms one
// root bit per cycle for all three channels, and results of one pixel go through
// it one after another. the next pixel is taken while the last result still waits
// in the output register.
// out_stall holds the output register; further results wait in the magnitude
// unit, and in_stall stays high until the pixel's results are all handed off.
// reset clears counters, window and output valid and loads width 640 and height
// 480; line store contents are undefined until a row has been written.
`default_nettype none
module sobel_edge_magnitude_rgb_top #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sobel_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        in_red,
	input  wire logic [7:0]                        in_green,
	input  wire logic [7:0]                        in_blue,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             edge_red,
	output logic [7:0]                             edge_green,
	output logic [7:0]                             edge_blue,
	output logic [$clog2(MAX_HEIGHT)-1:0]          out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]           out_col,
	output logic                                   last_of_run
);
	import sobel_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int MW   = (CW > RW) ? CW : RW;
	localparam int CMPW = ((MW > HEIGHT_W) ? MW : HEIGHT_W) + 2;

	ctl_state_t state_q, state_d;
	logic [WIDTH_W-1:0]  w_q;
	logic [HEIGHT_W-1:0] h_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	pcol_t wl_q, wc_q;
	pix_t px_q;
	pcol_t ctx_l_q, ctx_m_q, ctx_r_q;
	logic [CW-1:0] ctx_col_q;
	logic [RW-1:0] ctx_row_q;
	logic [3:0] mask_q;
	logic out_v_q;

	logic rd_en, wr_en, mag_start, load_out;
	logic [2*PIX_W-1:0] rd_data;
	logic mag_done;
	rgb8_t mag;

	logic [CMPW-1:0] w_ext, h_ext, weff, heff;
	logic endrow, lastrow;
	pcol_t cur, lft, ctr;
	logic [1:0] idx;
	logic [3:0] idx_oh;
	win_t win;

	always_comb begin
		w_ext = CMPW'(w_q);
		h_ext = CMPW'(h_q);
		if (w_q == '0) begin
			weff = CMPW'(1);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			weff = CMPW'(MAX_WIDTH);
		end else begin
			weff = w_ext;
		end
		if (h_q == '0) begin
			heff = CMPW'(1);
		end else if (h_ext > CMPW'(MAX_HEIGHT)) begin
			heff = CMPW'(MAX_HEIGHT);
		end else begin
			heff = h_ext;
		end
		endrow = (CMPW'(c_q) + CMPW'(1)) >= weff;
		lastrow = (CMPW'(r_q) + CMPW'(1)) >= heff;
	end

	always_comb begin
		cur[2] = px_q;
		cur[1] = (r_q >= RW'(1)) ? rd_data[PIX_W-1:0] : '0;
		cur[0] = (r_q >= RW'(2)) ? rd_data[2*PIX_W-1:PIX_W] : '0;
		lft = (c_q == '0) ? '0 : wl_q;
		ctr = (c_q == '0) ? '0 : wc_q;
	end

	always_comb begin
		pcol_t cl, cm, cr;
		if (mask_q[0]) begin
			idx = 2'd0;
		end else if (mask_q[1]) begin
			idx = 2'd1;
		end else if (mask_q[2]) begin
			idx = 2'd2;
		end else begin
			idx = 2'd3;
		end
		idx_oh = 4'd1 << idx;
		cl = idx[0] ? ctx_m_q : ctx_l_q;
		cm = idx[0] ? ctx_r_q : ctx_m_q;
		cr = idx[0] ? '0 : ctx_r_q;
		if (idx[1]) begin
			win[0] = {pix_t'(0), cl[2:1]};
			win[1] = {pix_t'(0), cm[2:1]};
			win[2] = {pix_t'(0), cr[2:1]};
		end else begin
			win[0] = cl;
			win[1] = cm;
			win[2] = cr;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		rd_en = 1'b0;
		wr_en = 1'b0;
		mag_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					rd_en = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				wr_en = 1'b1;
				if ((r_q != '0 || lastrow) && (c_q != '0 || endrow)) begin
					state_d = S_GO;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_GO: begin
				mag_start = 1'b1;
				state_d = S_BUSY;
			end
			S_BUSY: begin
				if (mag_done) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (!out_v_q) begin
					load_out = 1'b1;
					state_d = ((mask_q & ~idx_oh) != '0) ? S_GO : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q <= RST_WIDTH;
			h_q <= RST_HEIGHT;
			c_q <= '0;
			r_q <= '0;
			wl_q <= '0;
			wc_q <= '0;
			mask_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: w_q <= cfg_data[WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: h_q <= cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_RD) begin
				wl_q <= ctr;
				wc_q <= cur;
				mask_q <= {lastrow && endrow, lastrow && (c_q != '0),
					(r_q != '0) && endrow, (r_q != '0) && (c_q != '0)};
				if (endrow) begin
					c_q <= '0;
					r_q <= lastrow ? '0 : r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (load_out) begin
				mask_q <= mask_q & ~idx_oh;
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			px_q <= {in_red, in_green, in_blue};
		end
		if (state_q == S_RD) begin
			ctx_l_q <= lft;
			ctx_m_q <= ctr;
			ctx_r_q <= cur;
			ctx_col_q <= c_q;
			ctx_row_q <= r_q;
		end
		if (load_out) begin
			edge_red <= mag[2];
			edge_green <= mag[1];
			edge_blue <= mag[0];
			out_row <= idx[1] ? ctx_row_q : ctx_row_q - RW'(1);
			out_col <= idx[0] ? ctx_col_q : ctx_col_q - CW'(1);
			last_of_run <= (mask_q & ~idx_oh) == '0;
		end
	end

	assign out_valid = out_v_q;

	sobel_lbuf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_lbuf (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(c_q),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(c_q),
		.wr_data({rd_data[PIX_W-1:0], px_q})
	);

	sobel_mag u_mag (
		.clk(clk),
		.arst_n(arst_n),
		.start(mag_start),
		.win(win),
		.done(mag_done),
		.mag(mag)
	);

endmodule
`default_nettype wire

// ===== design/sobel_chk.sv =====
// sobel_chk: port-level checks for the sobel edge block, bound to the top level
// uses sobel_pkg widths; attaches to sobel_edge_magnitude_rgb_top
`default_nettype none
module sobel_chk #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [7:0]                   edge_red,
	input wire logic [7:0]                   edge_green,
	input wire logic [7:0]                   edge_blue,
	input wire logic [$clog2(MAX_HEIGHT)-1:0] out_row,
	input wire logic [$clog2(MAX_WIDTH)-1:0]  out_col,
	input wire logic                         last_of_run
);
	import sobel_pkg::*;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	a_busy_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> in_stall)
		else $error("input taken before all results of a pixel left");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped under stall");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(edge_red) && $stable(edge_green)
			&& $stable(edge_blue) && $stable(out_row) && $stable(out_col)
			&& $stable(last_of_run))
		else $error("output beat changed under stall");

endmodule

bind sobel_edge_magnitude_rgb_top sobel_chk #(
	.MAX_WIDTH(MAX_WIDTH),
	.MAX_HEIGHT(MAX_HEIGHT)
) u_sobel_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.edge_red(edge_red),
	.edge_green(edge_green),
	.edge_blue(edge_blue),
	.out_row(out_row),
	.out_col(out_col),
	.last_of_run(last_of_run)
);
`default_nettype wire
